/* sv/aging_priority_ready_queue_core_defines.svh */
`ifndef AGING_PRIORITY_READY_QUEUE_CORE_DEFINES_SVH
`define AGING_PRIORITY_READY_QUEUE_CORE_DEFINES_SVH

// clocked assertion, disabled in reset
`define APRQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// next-cycle implication
`define APRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	`APRQ_ASSERT(lbl, (ante) |=> (cons), msg)

// same-cycle implication
`define APRQ_ASSERT_SAME(lbl, ante, cons, msg) \
	`APRQ_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* sv/aprq_pkg.sv */
package aprq_pkg;

	localparam int PRIO_W = 6;
	localparam int DYN_W  = 8;

	typedef logic signed [PRIO_W-1:0] prio_t;
	typedef logic signed [DYN_W-1:0]  dyn_t;

	localparam prio_t PRIO_MIN  = prio_t'(-19);
	localparam prio_t PRIO_MAX  = prio_t'(19);
	localparam dyn_t  DYN_FLOOR = dyn_t'(-128);
	localparam dyn_t  AGE_STEP  = dyn_t'(1);

	typedef enum logic {
		CMD_ENQUEUE = 1'b0,
		CMD_PICK    = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_SETTLE,
		FSM_SHIFT,
		FSM_DRAIN
	} fsm_t;

endpackage

/* sv/aprq_req_if.sv */
interface aprq_req_if import aprq_pkg::*; #(
	parameter int ID_BITS = 8
) ();

	logic               valid;
	logic               ready;
	cmd_t               cmd;
	logic [ID_BITS-1:0] task_ident;
	prio_t              base_priority;

	modport source (output valid, output cmd, output task_ident, output base_priority,
		input ready);
	modport sink (input valid, input cmd, input task_ident, input base_priority,
		output ready);

endinterface

/* sv/aprq_rsp_if.sv */
interface aprq_rsp_if import aprq_pkg::*; #(
	parameter int ID_BITS = 8,
	parameter int OCC_W   = 5
) ();

	logic               valid;
	logic               ready;
	status_t            status;
	logic [ID_BITS-1:0] chosen_task;
	logic [OCC_W-1:0]   occupancy;

	modport source (output valid, output status, output chosen_task, output occupancy,
		input ready);
	modport sink (input valid, input status, input chosen_task, input occupancy,
		output ready);

endinterface

/* sv/aging_priority_ready_queue_core.sv */
// channel | dir | payload                              | handshake
// req     | in  | cmd, task_ident, base_priority       | valid/ready
// rsp     | out | status, chosen_task, occupancy       | valid/ready
//
// enqueue and picks on an empty queue load the result register in the accept cycle
// a pick reads every queued slot to scan the slot memory, settles the compare,
// then compacts and ages the remaining tasks with read/write steps, and drains the result
// these steps follow from the single-port read and single-port write slot memory
// arst_n clears the fill count, state and result valid flag; result payload and slot memory are not cleared
// rsp stalls hold the result; in idle, a new transaction is taken once the result can leave
module aging_priority_ready_queue_core import aprq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	aprq_req_if.sink     req,
	aprq_rsp_if.source   rsp
);

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [ID_BITS-1:0] task_id;
		prio_t              stat;
		dyn_t               dyn;
	} slot_t;

	slot_t slot_mem [QUEUE_DEPTH];

	fsm_t               fsm_q, fsm_nxt;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   idx_q;
	logic               cmp_vld_s1;
	logic               mv_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	slot_t              rd_data_s1;
	logic [IDX_W-1:0]   best_idx_q;
	dyn_t               best_dyn_q;
	logic [ID_BITS-1:0] best_task_q;

	logic               out_vld_q;
	status_t            out_status_q;
	logic [ID_BITS-1:0] out_task_q;
	logic [CNT_W-1:0]   out_occ_q;

	logic               req_ready;
	logic               accept;
	logic               out_load;
	logic               mem_re;
	logic [IDX_W-1:0]   mem_raddr;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	slot_t              mem_wdata;
	logic [IDX_W-1:0]   last_idx;
	logic [IDX_W-1:0]   shift_last;
	logic               full;
	prio_t              prio_clamped;
	dyn_t               dyn_aged;

	assign last_idx   = IDX_W'(cnt_q - CNT_W'(1));
	assign shift_last = IDX_W'(cnt_q - CNT_W'(2));
	assign full       = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign accept     = req.valid && req_ready;
	assign out_load   = (fsm_q == FSM_DRAIN) ||
		(fsm_q == FSM_IDLE && accept && (req.cmd == CMD_ENQUEUE || cnt_q == '0));

	always_comb begin
		if (req.base_priority < PRIO_MIN) begin
			prio_clamped = PRIO_MIN;
		end else if (req.base_priority > PRIO_MAX) begin
			prio_clamped = PRIO_MAX;
		end else begin
			prio_clamped = req.base_priority;
		end
	end

	assign dyn_aged = (rd_data_s1.dyn == DYN_FLOOR) ? DYN_FLOOR : dyn_t'(rd_data_s1.dyn - AGE_STEP);

	// next state
	always_comb begin
		fsm_nxt = fsm_q;
		unique case (fsm_q)
			FSM_IDLE: begin
				if (accept && req.cmd == CMD_PICK && cnt_q != '0) begin
					fsm_nxt = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				if (idx_q == last_idx) begin
					fsm_nxt = FSM_SETTLE;
				end
			end
			FSM_SETTLE: begin
				if (cnt_q == CNT_W'(1)) begin
					fsm_nxt = FSM_DRAIN;
				end else begin
					fsm_nxt = FSM_SHIFT;
				end
			end
			FSM_SHIFT: begin
				if (idx_q == shift_last) begin
					fsm_nxt = FSM_DRAIN;
				end
			end
			FSM_DRAIN: begin
				fsm_nxt = FSM_IDLE;
			end
			default: begin
				fsm_nxt = FSM_IDLE;
			end
		endcase
	end

	// outputs and memory control
	always_comb begin
		req_ready = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = idx_q;
		mem_we    = 1'b0;
		mem_waddr = rd_idx_s1;
		mem_wdata = '{task_id: rd_data_s1.task_id, stat: rd_data_s1.stat, dyn: dyn_aged};
		unique case (fsm_q)
			FSM_IDLE: begin
				req_ready = !out_vld_q || rsp.ready;
				if (accept && req.cmd == CMD_ENQUEUE && !full) begin
					mem_we    = 1'b1;
					mem_waddr = cnt_q[IDX_W-1:0];
					mem_wdata = '{task_id: req.task_ident, stat: prio_clamped,
						dyn: dyn_t'(prio_clamped)};
				end
			end
			FSM_SCAN: begin
				mem_re = 1'b1;
			end
			FSM_SETTLE: begin
			end
			FSM_SHIFT: begin
				mem_re    = 1'b1;
				mem_raddr = (idx_q >= best_idx_q) ? IDX_W'(idx_q + 1'b1) : idx_q;
				mem_we    = mv_vld_s1;
			end
			FSM_DRAIN: begin
				mem_we = mv_vld_s1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_data_s1 <= slot_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q      <= FSM_IDLE;
			cnt_q      <= '0;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			mv_vld_s1  <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			fsm_q      <= fsm_nxt;
			cmp_vld_s1 <= (fsm_q == FSM_SCAN);
			mv_vld_s1  <= (fsm_q == FSM_SHIFT);

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (fsm_q)
				FSM_IDLE: begin
					idx_q <= '0;
					if (accept && req.cmd == CMD_ENQUEUE && !full) begin
						cnt_q <= CNT_W'(cnt_q + 1'b1);
					end
				end
				FSM_SCAN: begin
					idx_q <= (idx_q == last_idx) ? '0 : IDX_W'(idx_q + 1'b1);
				end
				FSM_SETTLE: begin
					idx_q <= '0;
				end
				FSM_SHIFT: begin
					idx_q <= IDX_W'(idx_q + 1'b1);
				end
				FSM_DRAIN: begin
					cnt_q <= CNT_W'(cnt_q - 1'b1);
				end
				default: begin
				end
			endcase
		end
	end

	// result payload and scan tracking
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;

		if (cmp_vld_s1 && (rd_idx_s1 == '0 || rd_data_s1.dyn <= best_dyn_q)) begin
			best_idx_q  <= rd_idx_s1;
			best_dyn_q  <= rd_data_s1.dyn;
			best_task_q <= rd_data_s1.task_id;
		end

		if (fsm_q == FSM_IDLE && accept) begin
			out_task_q <= '0;
			if (req.cmd == CMD_ENQUEUE) begin
				out_status_q <= full ? STATUS_FULL : STATUS_OK;
				out_occ_q    <= full ? cnt_q : CNT_W'(cnt_q + 1'b1);
			end else begin
				out_status_q <= STATUS_EMPTY;
				out_occ_q    <= '0;
			end
		end else if (fsm_q == FSM_DRAIN) begin
			out_status_q <= STATUS_OK;
			out_task_q   <= best_task_q;
			out_occ_q    <= CNT_W'(cnt_q - 1'b1);
		end
	end

	assign req.ready       = req_ready;
	assign rsp.valid       = out_vld_q;
	assign rsp.status      = out_status_q;
	assign rsp.chosen_task = out_task_q;
	assign rsp.occupancy   = out_occ_q;

endmodule

/* sv/aprq_chk.sv */
`include "aging_priority_ready_queue_core_defines.svh"

module aprq_chk import aprq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	aprq_req_if.sink     req,
	aprq_rsp_if.source   rsp
);

	// stalled result holds
	`APRQ_ASSERT_NEXT(a_rsp_hold, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.status) && $stable(rsp.chosen_task) && $stable(rsp.occupancy), "result changed while stalled")

	// enqueue result is valid in the cycle after the transaction
	`APRQ_ASSERT_NEXT(a_enq_result, req.valid && req.ready && req.cmd == CMD_ENQUEUE, rsp.valid, "enqueue result missing")

	`APRQ_ASSERT_SAME(a_empty_zero, rsp.valid && rsp.status == STATUS_EMPTY, rsp.chosen_task == '0 && rsp.occupancy == '0, "empty pick with nonzero payload")

	`APRQ_ASSERT_SAME(a_full_occ, rsp.valid && rsp.status == STATUS_FULL, rsp.occupancy == QUEUE_DEPTH && rsp.chosen_task == '0, "full status with wrong occupancy")

	`APRQ_ASSERT_SAME(a_occ_range, rsp.valid, rsp.occupancy <= QUEUE_DEPTH, "occupancy beyond depth")

endmodule

bind aging_priority_ready_queue_core aprq_chk #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_aprq_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);

/* verif/tb_aging_priority_ready_queue_core.sv */
`timescale 1ns / 100ps

module tb_aging_priority_ready_queue_core;
	import aprq_pkg::*;

	localparam int DEPTH      = 16;
	localparam int ID_W       = 8;
	localparam int OCC_W      = 5;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 60;

	typedef struct packed {
		status_t         status;
		logic [ID_W-1:0] chosen;
		logic [OCC_W-1:0] occ;
	} sched_result_t;

	logic clk;
	logic arst_n;

	aprq_req_if #(.ID_BITS(ID_W)) req_ch ();
	aprq_rsp_if #(.ID_BITS(ID_W), .OCC_W(OCC_W)) rsp_ch ();

	aging_priority_ready_queue_core #(
		.QUEUE_DEPTH(DEPTH),
		.ID_BITS    (ID_W)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// shadow of the ready queue
	logic [ID_W-1:0] shadow_id [DEPTH];
	prio_t           shadow_base [DEPTH];
	dyn_t            shadow_dyn [DEPTH];
	int              shadow_fill;

	sched_result_t pending_results [$];
	int            mismatch_count;
	int            quiet_cycles;
	bit            idle_on;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic sched_result_t schedule_item(cmd_t c, logic [ID_W-1:0] id, prio_t p);
		sched_result_t r;
		prio_t         clamped;
		int            sel;
		r.status = STATUS_OK;
		r.chosen = '0;
		if (c == CMD_ENQUEUE) begin
			if (shadow_fill >= DEPTH) begin
				r.status = STATUS_FULL;
			end else begin
				clamped = p;
				if (clamped < PRIO_MIN) clamped = PRIO_MIN;
				if (clamped > PRIO_MAX) clamped = PRIO_MAX;
				shadow_id[shadow_fill]   = id;
				shadow_base[shadow_fill] = clamped;
				shadow_dyn[shadow_fill]  = dyn_t'(clamped);
				shadow_fill++;
			end
		end else if (shadow_fill == 0) begin
			r.status = STATUS_EMPTY;
		end else begin
			sel = 0;
			for (int k = 1; k < shadow_fill; k++) begin
				if (shadow_dyn[k] <= shadow_dyn[sel]) sel = k;
			end
			r.chosen = shadow_id[sel];
			for (int k = sel; k + 1 < shadow_fill; k++) begin
				shadow_id[k]   = shadow_id[k+1];
				shadow_base[k] = shadow_base[k+1];
				shadow_dyn[k]  = shadow_dyn[k+1];
			end
			shadow_fill--;
			// everyone left behind ages, floored
			for (int k = 0; k < shadow_fill; k++) begin
				if (shadow_dyn[k] != DYN_FLOOR) shadow_dyn[k] = shadow_dyn[k] - AGE_STEP;
			end
		end
		r.occ = OCC_W'(shadow_fill);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("error at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic send_item(input cmd_t c, input logic [ID_W-1:0] id, input prio_t p);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		req_ch.cmd           = c;
		req_ch.task_ident    = id;
		req_ch.base_priority = p;
		req_ch.valid         = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// predict on each accepted request, check each accepted result
	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n) begin
			quiet_cycles++;
			if (req_ch.valid && req_ch.ready) begin
				quiet_cycles = 0;
				pending_results.push_back(schedule_item(req_ch.cmd, req_ch.task_ident,
					req_ch.base_priority));
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				quiet_cycles = 0;
				if (pending_results.size() == 0) begin
					report_mismatch("result transaction with nothing outstanding");
				end else begin
					want = pending_results.pop_front();
					if (rsp_ch.status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							rsp_ch.status, want.status));
					if (rsp_ch.chosen_task !== want.chosen)
						report_mismatch($sformatf("chosen_task %0d, want %0d",
							rsp_ch.chosen_task, want.chosen));
					if (rsp_ch.occupancy !== want.occ)
						report_mismatch($sformatf("occupancy %0d, want %0d",
							rsp_ch.occupancy, want.occ));
				end
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// result side backpressure
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 4) == 0) begin
				rsp_ch.ready = 1'b0;
				repeat ($urandom_range(1, 10) - 1) @(negedge clk);
			end else begin
				rsp_ch.ready = 1'b1;
			end
		end
	end

	task automatic test_pick_empty();
		send_item(CMD_PICK, 8'hFF, prio_t'(-32));
	endtask

	task automatic test_fill_extremes();
		logic [ID_W-1:0] ids [16];
		int              prios [16];
		ids   = '{8'h00, 8'hFF, 8'hAA, 8'h55, 8'h01, 8'h02, 8'h07, 8'h07,
			8'h09, 8'h03, 8'h04, 8'h05, 8'h00, 8'hFF, 8'h06, 8'h08};
		prios = '{-32, 31, -20, 20, -19, 19, 5, 5, 5, 0, -1, 1, -19, 19, -7, 12};
		for (int k = 0; k < 16; k++) send_item(CMD_ENQUEUE, ids[k], prio_t'(prios[k]));
	endtask

	task automatic test_enqueue_full();
		send_item(CMD_ENQUEUE, 8'h5A, prio_t'(0));
	endtask

	task automatic test_pick_order();
		send_item(CMD_PICK, 8'h00, prio_t'(0));
		send_item(CMD_PICK, 8'hFF, prio_t'(-32));
		send_item(CMD_PICK, 8'hA5, prio_t'(31));
		send_item(CMD_PICK, 8'h5A, prio_t'(-1));
	endtask

	task automatic test_random_traffic(input int count);
		int              enq_pct;
		int              pct_table [5];
		cmd_t            c;
		logic [ID_W-1:0] id;
		prio_t           p;
		pct_table = '{90, 70, 50, 30, 10};
		enq_pct   = 50;
		for (int k = 0; k < count; k++) begin
			// phases that push toward full or toward empty
			if (k % 32 == 0) enq_pct = pct_table[$urandom_range(0, 4)];
			c = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_PICK;
			if ($urandom_range(0, 9) < 3) id = ID_W'($urandom_range(0, 3));
			else id = ID_W'($urandom_range(0, 255));
			if ($urandom_range(0, 3) != 0) p = prio_t'(int'($urandom_range(0, 38)) - 19);
			else p = prio_t'($urandom_range(0, 63));
			send_item(c, id, p);
		end
	endtask

	task automatic wait_for_drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	initial begin
		clk                  = 1'b0;
		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.cmd           = CMD_ENQUEUE;
		req_ch.task_ident    = '0;
		req_ch.base_priority = '0;
		shadow_fill          = 0;
		mismatch_count       = 0;
		quiet_cycles         = 0;
		idle_on              = 1'b1;
		for (int k = 0; k < DEPTH; k++) begin
			shadow_id[k]   = '0;
			shadow_base[k] = '0;
			shadow_dyn[k]  = '0;
		end
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_pick_empty();
		test_fill_extremes();
		test_enqueue_full();
		test_pick_order();
		test_random_traffic(400);
		idle_on = 1'b0;
		test_random_traffic(100);
		@(negedge clk);
		req_ch.valid = 1'b0;
		wait_for_drain();

		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
